// File: src/scov_pkg.sv
package scov_pkg;

  // Field and accumulator widths
  localparam int COORD_W  = 24;
  localparam int PROD_W   = 2 * COORD_W;
  localparam int SUM_W    = 36;
  localparam int PSUM_W   = 60;
  localparam int CNT_W    = 13;
  localparam int NUM_W    = 73;
  localparam int MAG_W    = NUM_W - 1;
  localparam int D_W      = 24;
  localparam int Q_W      = 48;
  localparam int VAR_W    = 47;

  // Shared multiplier: one chunk of the second operand per cycle
  localparam int MUL_CHUNK = 12;
  localparam int MUL_STEPS = SUM_W / MUL_CHUNK;
  localparam int STEP_W    = $clog2(MUL_STEPS);

  // Serial divider: one quotient bit per cycle
  localparam int DIV_CNT_W = $clog2(MAG_W);

  // Set queue between front and back
  localparam int QDEPTH  = 2;
  localparam int PTR_W   = $clog2(QDEPTH);
  localparam int LEVEL_W = $clog2(QDEPTH + 1);

  localparam int MAX_SAMPLES_DEF = 4096;

  typedef enum logic [1:0] {
    STAT_OK      = 2'd0,
    STAT_TOO_FEW = 2'd1,
    STAT_CAP     = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    ENT_XX = 3'd0,
    ENT_XY = 3'd1,
    ENT_XZ = 3'd2,
    ENT_YY = 3'd3,
    ENT_YZ = 3'd4,
    ENT_ZZ = 3'd5
  } entry_t;

  localparam int NUM_ENT = 6;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SETUP,
    S_M1_GO,
    S_M1_WAIT,
    S_M2_GO,
    S_M2_WAIT,
    S_DIFF,
    S_DIV_GO,
    S_DIV_WAIT,
    S_EMIT
  } back_state_t;

  // Accumulated totals of one sample set
  typedef struct packed {
    logic signed [SUM_W-1:0]  sum_x;
    logic signed [SUM_W-1:0]  sum_y;
    logic signed [SUM_W-1:0]  sum_z;
    logic signed [PSUM_W-1:0] sum_xx;
    logic signed [PSUM_W-1:0] sum_xy;
    logic signed [PSUM_W-1:0] sum_xz;
    logic signed [PSUM_W-1:0] sum_yy;
    logic signed [PSUM_W-1:0] sum_yz;
    logic signed [PSUM_W-1:0] sum_zz;
    logic [CNT_W-1:0]         count;
    logic                     overflowed;
  } acc_t;

endpackage

// File: src/scov_mul.sv
module scov_mul (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  input  logic signed [scov_pkg::PSUM_W-1:0] a,
  input  logic signed [scov_pkg::SUM_W-1:0]  b,
  output logic                               done,
  output logic signed [scov_pkg::NUM_W-1:0]  product
);
  import scov_pkg::*;

  logic                         run;
  logic [STEP_W-1:0]            step;
  logic [PSUM_W-1:0]            mag_a;
  logic [SUM_W-1:0]             mag_b;
  logic                         neg;
  logic [MAG_W-1:0]             acc;
  logic [PSUM_W+MUL_CHUNK-1:0]  part;
  logic signed [NUM_W-1:0]      mag_s;

  // Multiply by the top chunk of the second operand
  assign part = mag_a * mag_b[SUM_W-1 -: MUL_CHUNK];

  // Load magnitudes, then shift and add one chunk per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run   <= 1'b1;
        step  <= '0;
        acc   <= '0;
        mag_a <= a[PSUM_W-1] ? PSUM_W'(-a) : PSUM_W'(a);
        mag_b <= b[SUM_W-1] ? SUM_W'(-b) : SUM_W'(b);
        neg   <= a[PSUM_W-1] ^ b[SUM_W-1];
      end else if (run) begin
        acc   <= (acc << MUL_CHUNK) + MAG_W'(part);
        mag_b <= mag_b << MUL_CHUNK;
        step  <= step + STEP_W'(1);
        if (step == STEP_W'(MUL_STEPS - 1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Restore the sign
  assign mag_s   = {1'b0, acc};
  assign product = neg ? -mag_s : mag_s;

endmodule

// File: src/scov_div.sv
module scov_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [scov_pkg::MAG_W-1:0]  dividend,
  input  logic [scov_pkg::D_W-1:0]    divisor,
  output logic                        done,
  output logic [scov_pkg::Q_W-1:0]    quotient
);
  import scov_pkg::*;

  logic                  run;
  logic [DIV_CNT_W-1:0]  cnt;
  logic [MAG_W-1:0]      dvd;
  logic [D_W-1:0]        dsr;
  logic [D_W-1:0]        rem;
  logic [Q_W-1:0]        quo;
  logic [D_W:0]          rem_sh;
  logic [D_W:0]          diff;
  logic                  ge;

  // Trial subtract for one quotient bit
  assign rem_sh = {rem, dvd[MAG_W-1]};
  assign diff   = rem_sh - {1'b0, dsr};
  assign ge     = rem_sh >= {1'b0, dsr};

  // Restoring division, most significant bit first
  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
        cnt <= '0;
        dvd <= dividend;
        dsr <= divisor;
        rem <= '0;
        quo <= '0;
      end else if (run) begin
        rem <= ge ? diff[D_W-1:0] : rem_sh[D_W-1:0];
        quo <= {quo[Q_W-2:0], ge};
        dvd <= dvd << 1;
        cnt <= cnt + DIV_CNT_W'(1);
        if (cnt == DIV_CNT_W'(MAG_W - 1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quotient = quo;

endmodule

// File: src/scov_queue.sv
module scov_queue (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           push,
  input  scov_pkg::acc_t                 push_data,
  input  logic                           pop,
  output scov_pkg::acc_t                 head,
  output logic [scov_pkg::LEVEL_W-1:0]   level
);
  import scov_pkg::*;

  acc_t              mem [QDEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;

  // Store a finished set
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  // Advance pointers and track the fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
      level <= level + LEVEL_W'(push) - LEVEL_W'(pop);
    end
  end

  assign head = mem[rd_ptr];

endmodule

// File: src/scov_front.sv
module scov_front #(
  parameter int MAX_SAMPLES = scov_pkg::MAX_SAMPLES_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  logic signed [scov_pkg::COORD_W-1:0] sample_x,
  input  logic signed [scov_pkg::COORD_W-1:0] sample_y,
  input  logic signed [scov_pkg::COORD_W-1:0] sample_z,
  input  logic                                last_sample,
  input  logic [scov_pkg::LEVEL_W-1:0]        q_level,
  output logic                                push,
  output scov_pkg::acc_t                      push_data
);
  import scov_pkg::*;

  localparam logic [CNT_W-1:0] CAP = CNT_W'(MAX_SAMPLES);

  logic                       a_valid, a_last;
  logic signed [COORD_W-1:0]  a_x, a_y, a_z;
  logic                       b_valid, b_last;
  logic signed [COORD_W-1:0]  b_x, b_y, b_z;
  logic signed [PROD_W-1:0]   b_xx, b_xy, b_xz, b_yy, b_yz, b_zz;
  logic [LEVEL_W:0]           pending;
  acc_t                       acc;
  acc_t                       acc_next;

  // Hold requests while queued plus in-flight sets could fill the queue
  assign pending = (LEVEL_W+1)'(q_level) + (LEVEL_W+1)'(a_valid & a_last)
                 + (LEVEL_W+1)'(b_valid & b_last);
  assign busy    = pending >= (LEVEL_W+1)'(QDEPTH);

  // Register the accepted sample
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else begin
      a_valid <= start & ~busy;
    end
    a_last <= last_sample;
    a_x    <= sample_x;
    a_y    <= sample_y;
    a_z    <= sample_z;
  end

  // Form the six products
  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else begin
      b_valid <= a_valid;
    end
    b_last <= a_last;
    b_x    <= a_x;
    b_y    <= a_y;
    b_z    <= a_z;
    b_xx   <= a_x * a_x;
    b_xy   <= a_x * a_y;
    b_xz   <= a_x * a_z;
    b_yy   <= a_y * a_y;
    b_yz   <= a_y * a_z;
    b_zz   <= a_z * a_z;
  end

  // Accumulate below capacity, flag samples past it
  always_comb begin
    acc_next = acc;
    if (b_valid) begin
      if (acc.count < CAP) begin
        acc_next.sum_x  = acc.sum_x  + SUM_W'(b_x);
        acc_next.sum_y  = acc.sum_y  + SUM_W'(b_y);
        acc_next.sum_z  = acc.sum_z  + SUM_W'(b_z);
        acc_next.sum_xx = acc.sum_xx + PSUM_W'(b_xx);
        acc_next.sum_xy = acc.sum_xy + PSUM_W'(b_xy);
        acc_next.sum_xz = acc.sum_xz + PSUM_W'(b_xz);
        acc_next.sum_yy = acc.sum_yy + PSUM_W'(b_yy);
        acc_next.sum_yz = acc.sum_yz + PSUM_W'(b_yz);
        acc_next.sum_zz = acc.sum_zz + PSUM_W'(b_zz);
        acc_next.count  = acc.count + CNT_W'(1);
      end else begin
        acc_next.overflowed = 1'b1;
      end
    end
  end

  // Hand the set to the queue on the last sample
  assign push      = b_valid & b_last;
  assign push_data = acc_next;

  // Update accumulators, clear after a handed-off set
  always_ff @(posedge clk) begin
    if (rst || push) begin
      acc <= '0;
    end else begin
      acc <= acc_next;
    end
  end

endmodule

// File: src/scov_back.sv
module scov_back (
  input  logic                                clk,
  input  logic                                rst,
  input  logic [scov_pkg::LEVEL_W-1:0]        q_level,
  input  scov_pkg::acc_t                      head,
  output logic                                pop,
  output logic                                done,
  output logic [scov_pkg::VAR_W-1:0]          var_x,
  output logic signed [scov_pkg::Q_W-1:0]     cov_xy,
  output logic signed [scov_pkg::Q_W-1:0]     cov_xz,
  output logic [scov_pkg::VAR_W-1:0]          var_y,
  output logic signed [scov_pkg::Q_W-1:0]     cov_yz,
  output logic [scov_pkg::VAR_W-1:0]          var_z,
  output logic [scov_pkg::CNT_W-1:0]          samples_used,
  output logic [1:0]                          status
);
  import scov_pkg::*;

  back_state_t               state, state_next;
  acc_t                      job;
  entry_t                    entry;
  logic [D_W-1:0]            d;
  logic [2*CNT_W-1:0]        nn;
  logic signed [NUM_W-1:0]   p1;
  logic signed [NUM_W-1:0]   num;
  logic [Q_W-1:0]            res [NUM_ENT];
  status_t                   stat;
  logic [CNT_W-1:0]          used;

  logic                      mul_start, mul_done;
  logic signed [PSUM_W-1:0]  mul_a;
  logic signed [SUM_W-1:0]   mul_b;
  logic signed [NUM_W-1:0]   mul_product;
  logic                      div_start, div_done;
  logic [MAG_W-1:0]          div_dividend;
  logic [Q_W-1:0]            div_quotient;

  logic signed [PSUM_W-1:0]  sab;
  logic signed [SUM_W-1:0]   sa, sb;

  // Pick the sums for the current matrix entry
  always_comb begin
    unique case (entry)
      ENT_XX: begin sab = job.sum_xx; sa = job.sum_x; sb = job.sum_x; end
      ENT_XY: begin sab = job.sum_xy; sa = job.sum_x; sb = job.sum_y; end
      ENT_XZ: begin sab = job.sum_xz; sa = job.sum_x; sb = job.sum_z; end
      ENT_YY: begin sab = job.sum_yy; sa = job.sum_y; sb = job.sum_y; end
      ENT_YZ: begin sab = job.sum_yz; sa = job.sum_y; sb = job.sum_z; end
      ENT_ZZ: begin sab = job.sum_zz; sa = job.sum_z; sb = job.sum_z; end
      default: begin sab = '0; sa = '0; sb = '0; end
    endcase
  end

  // First product n*Sab, second product Sa*Sb
  assign mul_a = (state == S_M1_GO) ? sab : PSUM_W'(sa);
  assign mul_b = (state == S_M1_GO) ? $signed(SUM_W'(job.count)) : sb;

  assign nn           = job.count * (job.count - CNT_W'(1));
  assign div_dividend = num[NUM_W-1] ? MAG_W'(-num) : MAG_W'(num);

  scov_mul u_mul (
    .clk     (clk),
    .rst     (rst),
    .start   (mul_start),
    .a       (mul_a),
    .b       (mul_b),
    .done    (mul_done),
    .product (mul_product)
  );

  scov_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (d),
    .done     (div_done),
    .quotient (div_quotient)
  );

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (q_level != '0) begin
          state_next = (head.count < CNT_W'(2)) ? S_EMIT : S_SETUP;
        end
      end
      S_SETUP:   state_next = S_M1_GO;
      S_M1_GO:   state_next = S_M1_WAIT;
      S_M1_WAIT: if (mul_done) state_next = S_M2_GO;
      S_M2_GO:   state_next = S_M2_WAIT;
      S_M2_WAIT: if (mul_done) state_next = S_DIFF;
      S_DIFF:    state_next = S_DIV_GO;
      S_DIV_GO:  state_next = S_DIV_WAIT;
      S_DIV_WAIT: begin
        if (div_done) begin
          state_next = (entry == ENT_ZZ) ? S_EMIT : S_M1_GO;
        end
      end
      S_EMIT:    state_next = S_IDLE;
      default:   state_next = S_IDLE;
    endcase
  end

  // Control outputs
  always_comb begin
    pop       = 1'b0;
    mul_start = 1'b0;
    div_start = 1'b0;
    done      = 1'b0;
    unique case (state)
      S_IDLE:   pop       = (q_level != '0);
      S_M1_GO:  mul_start = 1'b1;
      S_M2_GO:  mul_start = 1'b1;
      S_DIV_GO: div_start = 1'b1;
      S_EMIT:   done      = 1'b1;
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        if (q_level != '0) begin
          job   <= head;
          used  <= head.count;
          entry <= ENT_XX;
          for (int i = 0; i < NUM_ENT; i++) begin
            res[i] <= '0;
          end
          if (head.count < CNT_W'(2)) begin
            stat <= STAT_TOO_FEW;
          end else if (head.overflowed) begin
            stat <= STAT_CAP;
          end else begin
            stat <= STAT_OK;
          end
        end
      end
      S_SETUP: d <= D_W'(nn);
      S_M1_WAIT: if (mul_done) p1 <= mul_product;
      S_DIFF: num <= p1 - mul_product;
      S_DIV_WAIT: begin
        if (div_done) begin
          res[entry] <= num[NUM_W-1] ? -div_quotient : div_quotient;
          if (entry != ENT_ZZ) begin
            entry <= entry_t'(entry + 3'd1);
          end
        end
      end
      default: begin
      end
    endcase
  end

  assign var_x        = res[ENT_XX][VAR_W-1:0];
  assign cov_xy       = res[ENT_XY];
  assign cov_xz       = res[ENT_XZ];
  assign var_y        = res[ENT_YY][VAR_W-1:0];
  assign cov_yz       = res[ENT_YZ];
  assign var_z        = res[ENT_ZZ][VAR_W-1:0];
  assign samples_used = used;
  assign status       = stat;

endmodule

// File: src/sample_covariance_3d_top.sv
// Channel   Handshake          Payload
// sample    start / busy       sample_x, sample_y, sample_z, last_sample
// result    done (strobe)      var_x, cov_xy, cov_xz, var_y, cov_yz, var_z,
//                              samples_used, status
//
// A sample is taken on every cycle with start high and busy low; the front
// pipeline accumulates one sample per cycle. A finished set waits in a
// two-entry queue; busy rises while queued sets plus sets in flight fill it.
// The back end works through six entries per set from pop to result,
// each two passes of a 60x12 multiplier and a 72-step serial divider.
// A set of fewer than two samples skips the multiplier and divider and
// is reported straight from the queue.
// rst is synchronous and clears accumulators, queue and sequencer.
// The result is on the ports for the one cycle done is high; no stall.
module sample_covariance_3d_top #(
  parameter int MAX_SAMPLES = scov_pkg::MAX_SAMPLES_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  logic signed [scov_pkg::COORD_W-1:0] sample_x,
  input  logic signed [scov_pkg::COORD_W-1:0] sample_y,
  input  logic signed [scov_pkg::COORD_W-1:0] sample_z,
  input  logic                                last_sample,
  output logic                                done,
  output logic [scov_pkg::VAR_W-1:0]          var_x,
  output logic signed [scov_pkg::Q_W-1:0]     cov_xy,
  output logic signed [scov_pkg::Q_W-1:0]     cov_xz,
  output logic [scov_pkg::VAR_W-1:0]          var_y,
  output logic signed [scov_pkg::Q_W-1:0]     cov_yz,
  output logic [scov_pkg::VAR_W-1:0]          var_z,
  output logic [scov_pkg::CNT_W-1:0]          samples_used,
  output logic [1:0]                          status
);
  import scov_pkg::*;

  logic                push;
  acc_t                push_data;
  logic                pop;
  acc_t                head;
  logic [LEVEL_W-1:0]  q_level;

  scov_front #(
    .MAX_SAMPLES (MAX_SAMPLES)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .sample_x    (sample_x),
    .sample_y    (sample_y),
    .sample_z    (sample_z),
    .last_sample (last_sample),
    .q_level     (q_level),
    .push        (push),
    .push_data   (push_data)
  );

  scov_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (head),
    .level     (q_level)
  );

  scov_back u_back (
    .clk          (clk),
    .rst          (rst),
    .q_level      (q_level),
    .head         (head),
    .pop          (pop),
    .done         (done),
    .var_x        (var_x),
    .cov_xy       (cov_xy),
    .cov_xz       (cov_xz),
    .var_y        (var_y),
    .cov_yz       (cov_yz),
    .var_z        (var_z),
    .samples_used (samples_used),
    .status       (status)
  );

endmodule
